### sv/pipray_pkg.sv
// Shared constants, types and helpers for the ray crossing point-in-polygon core.
package pipray_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 32;
	localparam int VTX_W        = 2 * COORD_W;
	// shifted vertex minus test point, and edge vector widths
	localparam int G_W          = COORD_W + 2;
	localparam int E_W          = COORD_W + 1;
	// shared multiplier operand and product widths
	localparam int MUL_W        = G_W + 1;
	localparam int PROD_W       = 2 * MUL_W;
	// magnitudes used by the displacement divider
	localparam int AN_W         = 2 * G_W;
	localparam int HALF_W       = AN_W / 2;
	localparam int PW           = 100;
	localparam int RW           = 67;
	localparam int DIV_CNT_W    = 7;
	localparam int DIV_LAST     = PW - 1;
	localparam int DRAIN_LAST   = 3;

	localparam int S_TDATA_W    = 200;
	localparam int M_TDATA_W    = 72;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_QUERY   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DMUL1,
		ST_DSUB,
		ST_DABS,
		ST_DMUL2,
		ST_DLOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic neg;
		logic nz;
	} sgn_t;

	typedef struct packed {
		logic signed [G_W-1:0] x;
		logic signed [G_W-1:0] y;
	} gvec_t;

	function automatic sgn_t sgn_of(input logic signed [PROD_W-1:0] v);
		sgn_t s;
		s.neg = v[PROD_W-1];
		s.nz  = |v;
		return s;
	endfunction

endpackage

### sv/pipray_ram.sv
// Generic single-port synchronous RAM with registered read data.
module pipray_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### sv/point_in_polygon_ray_crossing_core.sv
// Top level of the even-odd ray crossing point-in-polygon core.
// A load transaction (tuser 0) writes one vertex into the 64-entry vertex RAM and gives
// no result. A query transaction (tuser 1) reads the vertices 0..n-1 and vertex 0 again
// from the single RAM port, one per cycle, through a four-stage pipeline (read, shift,
// four shared multipliers, sign test), n being vertex_count capped at 64. With
// displacement requested and the point inside, the same multipliers form the edge and
// ray cross products and a radix-2 restoring divider then computes the displacement. One
// query is in flight at a time; the result sits in an output register so the next
// transaction is taken while it waits. The user writes vertex_count on the cfg port only
// while no query is running; the core itself does not enforce this. Vertices must be loaded
// before a query reads them.
module point_in_polygon_ray_crossing_core
	import pipray_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// vertex_index, coord_x, coord_y, ray_dir_x, ray_dir_y, offset_x, offset_y,
	// convex_early_exit, want_displacement
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// opcode
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// inside_res, crossing_count, disp_x, disp_y
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]          vc_q, nv_q, rd_idx_q, cnt_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, dx_q, dy_q, ox_q, oy_q;
	logic                      conv_q, want_q, stop_q, hit_q, use_disp_q;
	logic [1:0]                drain_q;

	// input field split
	logic [ADDR_W-1:0]         in_idx;
	logic signed [COORD_W-1:0] in_x, in_y, in_dx, in_dy, in_ox, in_oy;
	logic                      in_conv, in_want, accept;

	assign in_idx  = s_axis_tdata[5:0];
	assign in_x    = s_axis_tdata[37:6];
	assign in_y    = s_axis_tdata[69:38];
	assign in_dx   = s_axis_tdata[101:70];
	assign in_dy   = s_axis_tdata[133:102];
	assign in_ox   = s_axis_tdata[165:134];
	assign in_oy   = s_axis_tdata[197:166];
	assign in_conv = s_axis_tdata[198];
	assign in_want = s_axis_tdata[199];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// vertex RAM, one port shared by loads and the edge walk
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [VTX_W-1:0]  ram_rdata;

	assign ram_we   = accept && (s_axis_tuser == OP_LOAD);
	assign ram_addr = (state_q == ST_IDLE) ? in_idx :
		(rd_idx_q == nv_q) ? '0 : rd_idx_q[ADDR_W-1:0];

	pipray_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES)
	) u_vram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({in_y, in_x}),
		.rdata(ram_rdata)
	);

	// walk pipeline
	logic  rd_v_s1, first_s1, v_s2, first_s2, v_s3, first_s3;
	gvec_t g_s2, g_s3, gp_s3, gp_q, g_d;
	logic signed [PROD_W-1:0] p0_s3, p1_s3, p2_s3, p3_s3;
	sgn_t  cprev_q;

	// shift the stored vertex and take the test point off
	always_comb begin
		g_d.x = G_W'(signed'(ram_rdata[COORD_W-1:0])) + G_W'(ox_q) - G_W'(cx_q);
		g_d.y = G_W'(signed'(ram_rdata[VTX_W-1:COORD_W])) + G_W'(oy_q) - G_W'(cy_q);
	end

	// shared multipliers: walk cross products, then displacement terms
	logic signed [MUL_W-1:0]  a0, b0, a1, b1, a2, b2, a3, b3;
	logic signed [G_W-1:0]    hg1x_q, hg1y_q;
	logic signed [E_W-1:0]    hex_q, hey_q;
	logic [AN_W-1:0]          an_q;
	logic [RW-1:0]            ad_q;
	logic [COORD_W-1:0]       mx, my;

	assign mx = dx_q[COORD_W-1] ? COORD_W'(-dx_q) : dx_q;
	assign my = dy_q[COORD_W-1] ? COORD_W'(-dy_q) : dy_q;

	always_comb begin
		a0 = MUL_W'(dx_q);   b0 = MUL_W'(g_s2.y);
		a1 = MUL_W'(dy_q);   b1 = MUL_W'(g_s2.x);
		a2 = MUL_W'(gp_q.x); b2 = MUL_W'(g_s2.y);
		a3 = MUL_W'(gp_q.y); b3 = MUL_W'(g_s2.x);
		unique case (state_q)
			ST_DMUL1: begin
				a0 = MUL_W'(hex_q); b0 = MUL_W'(hg1y_q);
				a1 = MUL_W'(hey_q); b1 = MUL_W'(hg1x_q);
				a2 = MUL_W'(hex_q); b2 = MUL_W'(dy_q);
				a3 = MUL_W'(dx_q);  b3 = MUL_W'(hey_q);
			end
			ST_DMUL2: begin
				a0 = MUL_W'({1'b0, mx}); b0 = MUL_W'({1'b0, an_q[HALF_W-1:0]});
				a1 = MUL_W'({1'b0, mx}); b1 = MUL_W'({1'b0, an_q[AN_W-1:HALF_W]});
				a2 = MUL_W'({1'b0, my}); b2 = MUL_W'({1'b0, an_q[HALF_W-1:0]});
				a3 = MUL_W'({1'b0, my}); b3 = MUL_W'({1'b0, an_q[AN_W-1:HALF_W]});
			end
			default: begin
			end
		endcase
	end

	// differences of product pairs and their signs
	logic signed [PROD_W-1:0] d01, d23;
	sgn_t  c_cur, gx_cur;
	logic  edge_v, crossed;

	assign d01    = p0_s3 - p1_s3;
	assign d23    = p2_s3 - p3_s3;
	assign c_cur  = sgn_of(d01);
	assign gx_cur = sgn_of(d23);
	assign edge_v = v_s3 && !first_s3;
	// no crossing when both ends lie strictly on one side; else the sign of g1 x g2 decides
	assign crossed = edge_v && !stop_q
		&& !(cprev_q.nz && c_cur.nz && (cprev_q.neg == c_cur.neg))
		&& gx_cur.nz && cprev_q.nz && (gx_cur.neg != cprev_q.neg);

	// advance the walk pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_WALK);
			v_s2    <= rd_v_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (rd_idx_q == '0);
		first_s2 <= first_s1;
		g_s2     <= g_d;
		first_s3 <= first_s2;
		g_s3     <= g_s2;
		gp_s3    <= gp_q;
		p0_s3    <= a0 * b0;
		p1_s3    <= a1 * b1;
		p2_s3    <= a2 * b2;
		p3_s3    <= a3 * b3;
		if (v_s2) begin
			gp_q <= g_s2;
		end
		if (v_s3) begin
			cprev_q <= c_cur;
		end
	end

	// divider datapath
	logic [PW-1:0]        qx_q, qy_q;
	logic [RW-1:0]        remx_q, remy_q, remx_sh, remy_sh;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 negx_q, negy_q, zx_q, zy_q;
	logic signed [PROD_W-1:0] num_q, den_q;

	assign remx_sh = {remx_q[RW-2:0], qx_q[PW-1]};
	assign remy_sh = {remy_q[RW-2:0], qy_q[PW-1]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_axis_tuser == OP_QUERY) begin
					state_d = (in_conv || !in_conv) && (vc_q == '0) ? ST_FIN : ST_WALK;
				end
			end
			ST_WALK:  if (rd_idx_q == nv_q) state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (drain_q == 2'(DRAIN_LAST)) begin
					state_d = (cnt_q[0] && hit_q && want_q) ? ST_DMUL1 : ST_FIN;
				end
			end
			ST_DMUL1: state_d = ST_DSUB;
			ST_DSUB:  state_d = ST_DABS;
			ST_DABS:  state_d = ST_DMUL2;
			ST_DMUL2: state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV:   if (div_cnt_q == DIV_CNT_W'(DIV_LAST)) state_d = ST_FIN;
			ST_FIN:   if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_data;
		end
	end

	// query control: capture, read walk, crossing count, hit record, drain and divider counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			stop_q     <= 1'b0;
			hit_q      <= 1'b0;
			use_disp_q <= 1'b0;
			rd_idx_q   <= '0;
			drain_q    <= '0;
			div_cnt_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && accept) begin
				cnt_q      <= '0;
				stop_q     <= 1'b0;
				hit_q      <= 1'b0;
				use_disp_q <= 1'b0;
				rd_idx_q   <= '0;
			end
			if (state_q == ST_WALK) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				drain_q  <= '0;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end
			if (crossed) begin
				cnt_q <= cnt_q + 1'b1;
				hit_q <= 1'b1;
				if (conv_q && cnt_q == CNT_W'(1)) begin
					stop_q <= 1'b1;
				end
			end
			if (state_q == ST_DMUL1) begin
				use_disp_q <= 1'b1;
			end
			if (state_q == ST_DLOAD) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// query payload and displacement datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			cx_q   <= in_x;
			cy_q   <= in_y;
			dx_q   <= in_dx;
			dy_q   <= in_dy;
			ox_q   <= in_ox;
			oy_q   <= in_oy;
			conv_q <= in_conv;
			want_q <= in_want;
			nv_q   <= (vc_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_q;
		end
		if (crossed) begin
			hg1x_q <= gp_s3.x;
			hg1y_q <= gp_s3.y;
			hex_q  <= E_W'(g_s3.x - gp_s3.x);
			hey_q  <= E_W'(g_s3.y - gp_s3.y);
		end
		unique case (state_q)
			ST_DSUB: begin
				num_q <= d01;
				den_q <= d23;
			end
			ST_DABS: begin
				an_q   <= AN_W'(num_q[PROD_W-1] ? -num_q : num_q);
				ad_q   <= RW'(den_q[PROD_W-1] ? -den_q : den_q);
				zx_q   <= (den_q == '0) || (num_q == '0) || (dx_q == '0);
				zy_q   <= (den_q == '0) || (num_q == '0) || (dy_q == '0);
				negx_q <= dx_q[COORD_W-1] ^ num_q[PROD_W-1] ^ den_q[PROD_W-1];
				negy_q <= dy_q[COORD_W-1] ^ num_q[PROD_W-1] ^ den_q[PROD_W-1];
			end
			ST_DLOAD: begin
				qx_q   <= PW'(p0_s3[2*HALF_W-3:0]) + {p1_s3[PW-HALF_W-1:0], {HALF_W{1'b0}}};
				qy_q   <= PW'(p2_s3[2*HALF_W-3:0]) + {p3_s3[PW-HALF_W-1:0], {HALF_W{1'b0}}};
				remx_q <= '0;
				remy_q <= '0;
			end
			ST_DIV: begin
				// one restoring step per cycle on each component
				if (remx_sh >= ad_q) begin
					remx_q <= remx_sh - ad_q;
					qx_q   <= {qx_q[PW-2:0], 1'b1};
				end else begin
					remx_q <= remx_sh;
					qx_q   <= {qx_q[PW-2:0], 1'b0};
				end
				if (remy_sh >= ad_q) begin
					remy_q <= remy_sh - ad_q;
					qy_q   <= {qy_q[PW-2:0], 1'b1};
				end else begin
					remy_q <= remy_sh;
					qy_q   <= {qy_q[PW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// saturate the quotients to signed coordinates
	logic [COORD_W-1:0] disp_x, disp_y;
	localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

	always_comb begin
		disp_x = '0;
		disp_y = '0;
		if (use_disp_q && !zx_q) begin
			if (negx_q) begin
				disp_x = (qx_q > PW'(SAT_NEG)) ? SAT_NEG : COORD_W'(-qx_q);
			end else begin
				disp_x = (qx_q > PW'(SAT_POS)) ? SAT_POS : qx_q[COORD_W-1:0];
			end
		end
		if (use_disp_q && !zy_q) begin
			if (negy_q) begin
				disp_y = (qy_q > PW'(SAT_NEG)) ? SAT_NEG : COORD_W'(-qy_q);
			end else begin
				disp_y = (qy_q > PW'(SAT_POS)) ? SAT_POS : qy_q[COORD_W-1:0];
			end
		end
	end

	// output register
	logic m_tvalid_q;
	assign m_axis_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!m_tvalid_q || m_axis_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!m_tvalid_q || m_axis_tready)) begin
			m_axis_tdata <= {disp_y, disp_x, cnt_q, cnt_q[0]};
		end
	end

	// checks
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[1]))
		else $error("inside flag disagrees with crossing parity");
	a_disp_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[71:8] == '0))
		else $error("displacement given for an outside point");
	a_convex: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && conv_q) |-> (cnt_q <= CNT_W'(2)))
		else $error("convex walk counted past two crossings");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_v_s1 && !v_s2 && !v_s3))
		else $error("walk pipeline busy while idle");

endmodule
